// ===== rtl/core/sppi_pkg.sv =====
`default_nettype none

package sppi_pkg;

	typedef enum logic [2:0] {
		OP_STATUS_RD = 3'd0,
		OP_DATA_RD   = 3'd1,
		OP_DATA_WR   = 3'd2,
		OP_CTRL_WR   = 3'd3,
		OP_RX_ARRIVE = 3'd4,
		OP_PORT_RST  = 3'd5,
		OP_IRQ_SET   = 3'd6,
		OP_IRQ_CLR   = 3'd7
	} op_t;

	localparam logic [7:0] ST_RX_FULL  = 8'h01;
	localparam logic [7:0] ST_TX_EMPTY = 8'h02;
	localparam logic [7:0] ST_IRQ      = 8'h80;
	localparam logic [7:0] CR_RX_IE    = 8'h80;
	localparam logic [7:0] CR_TX_MASK  = 8'h60;
	localparam logic [7:0] CR_TX_IE    = 8'h20;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} req_t;

	typedef struct packed {
		logic [2:0] irq_level;
		logic [7:0] tx_data;
		logic       tx_valid;
		logic [7:0] read_data;
	} result_t;

	// highest pending level; level 0 never counts
	function automatic logic [2:0] highest_level(input logic [7:0] mask);
		logic [2:0] lvl;
		lvl = 3'd0;
		for (int k = 1; k < 8; k++) begin
			if (mask[k]) lvl = 3'(k);
		end
		return lvl;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sppi_engine.sv =====
`default_nettype none

module sppi_engine #(
	parameter int SERIAL_IRQ_LEVEL = 5
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               fire,
	input  wire sppi_pkg::req_t req,
	output sppi_pkg::result_t res
);

	localparam logic [7:0] PortBit = 8'(1) << SERIAL_IRQ_LEVEL;

	logic [7:0] control_q, status_q, rx_hold_q, mask_q;
	logic [7:0] control_n, status_n, rx_hold_n, mask_n;

	always_comb begin
		control_n     = control_q;
		status_n      = status_q;
		rx_hold_n     = rx_hold_q;
		mask_n        = mask_q;
		res.read_data = 8'd0;
		res.tx_valid  = 1'b0;
		res.tx_data   = 8'd0;
		unique case (req.op)
			sppi_pkg::OP_STATUS_RD: begin
				res.read_data = status_q;
			end
			sppi_pkg::OP_DATA_RD: begin
				mask_n        = mask_q & ~PortBit;
				status_n      = status_q & ~(sppi_pkg::ST_IRQ | sppi_pkg::ST_RX_FULL);
				res.read_data = rx_hold_q;
			end
			sppi_pkg::OP_DATA_WR: begin
				res.tx_valid = 1'b1;
				res.tx_data  = req.data;
				if ((control_q & sppi_pkg::CR_TX_MASK) == sppi_pkg::CR_TX_IE) begin
					mask_n = mask_q | PortBit;
				end
			end
			sppi_pkg::OP_CTRL_WR: begin
				control_n = req.data;
			end
			sppi_pkg::OP_RX_ARRIVE: begin
				rx_hold_n = req.data;
				status_n  = status_q | sppi_pkg::ST_RX_FULL;
				if (((control_q & sppi_pkg::CR_RX_IE) != 8'd0)
						&& ((status_q & sppi_pkg::ST_IRQ) == 8'd0)) begin
					mask_n   = mask_q | PortBit;
					status_n = status_q | sppi_pkg::ST_RX_FULL | sppi_pkg::ST_IRQ;
				end
			end
			sppi_pkg::OP_PORT_RST: begin
				control_n = 8'd0;
				status_n  = sppi_pkg::ST_TX_EMPTY;
				mask_n    = mask_q & ~PortBit;
			end
			sppi_pkg::OP_IRQ_SET: begin
				if (req.data[7:3] == 5'd0) mask_n = mask_q | (8'(1) << req.data[2:0]);
			end
			sppi_pkg::OP_IRQ_CLR: begin
				if (req.data[7:3] == 5'd0) mask_n = mask_q & ~(8'(1) << req.data[2:0]);
			end
		endcase
		res.irq_level = sppi_pkg::highest_level(mask_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= 8'd0;
			status_q  <= sppi_pkg::ST_TX_EMPTY;
			rx_hold_q <= 8'd0;
			mask_q    <= 8'd0;
		end else if (fire) begin
			control_q <= control_n;
			status_q  <= status_n;
			rx_hold_q <= rx_hold_n;
			mask_q    <= mask_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/serial_port_with_priority_interrupts.sv =====
// Serial port with an eight-level priority interrupt controller. Each request
// is one operation, selected by s_tuser: status read, data read, data write,
// control write, receive arrival, port reset, interrupt level set or clear.
// Every request gives exactly one result carrying the read byte, the
// transmitted byte and its flag, and the highest pending interrupt level.
// A request is held in the input register and is then applied to the port
// state and captured in the output register; a new request is taken every
// cycle while the output is drained.

`default_nettype none

module serial_port_with_priority_interrupts #(
	parameter int SERIAL_IRQ_LEVEL = 5
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data
	input  wire  [2:0]  s_tuser,   // [2:0] op
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // [7:0] read_data, [15:8] tx_data, [18:16] irq_level
	output logic        m_tuser    // [0] tx_valid
);

	logic              valid_s1;
	sppi_pkg::req_t    req_s1;
	sppi_pkg::result_t res_c;
	sppi_pkg::result_t res_s2;
	logic              valid_s2;
	logic              adv;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else if (s_tready && s_tvalid) begin
			req_s1.op   <= sppi_pkg::op_t'(s_tuser);
			req_s1.data <= s_tdata;
		end
	end

	sppi_engine #(
		.SERIAL_IRQ_LEVEL(SERIAL_IRQ_LEVEL)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.req    (req_s1),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s2 <= res_c;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.tx_valid;
	assign m_tdata  = {5'd0, res_s2.irq_level, res_s2.tx_data, res_s2.read_data};

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input stalled with empty input register");

	a_tx_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && req_s1.op == sppi_pkg::OP_DATA_WR) |=> (m_tvalid && m_tuser))
		else $error("data write did not produce a transmit byte");

	a_status_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && req_s1.op == sppi_pkg::OP_STATUS_RD) |=> (m_tdata[6:2] == 5'd0))
		else $error("status read returned undefined bits");

endmodule

`default_nettype wire
